[hw/rtl/cer_pkg.sv]
// Package for the K=7 rate-1/2 convolutional encoder with repetition.
// Holds the mode codes, tap constants, sizes and the encode result type.
// No dependencies.
package cer_pkg;

  typedef enum logic [1:0] {
    MODE_BYPASS    = 2'd0,
    MODE_RATE_HALF = 2'd1,
    MODE_REPEAT2   = 2'd2,
    MODE_REPEAT4   = 2'd3
  } mode_t;

  localparam logic [6:0] TAP_P1 = 7'h5b;
  localparam logic [6:0] TAP_P2 = 7'h79;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 4;   // bit count field, 0..15; counts above 8 are taken as 8
  localparam int HIST_W = 6;
  localparam int BUF_W  = 64;  // up to eight coded bytes per item
  localparam int TOT_W  = 7;   // coded bit total, 0..64

  localparam logic [CNT_W-1:0] MAX_BITS = 4'd8;

  // One item's coded bits (MSB first), their number and the next history.
  typedef struct packed {
    logic [BUF_W-1:0]  bits;
    logic [TOT_W-1:0]  total;
    logic [HIST_W-1:0] hist;
  } enc_res_t;

endpackage

[hw/rtl/conv_encoder_k7_rate_half_repeat.sv]
// Each accepted item waits in the input register, then moves to the result register,
// which hands out one byte a cycle while out_tready is high: at most 1 (bypass),
// 2 (rate half), 4, 8 (repeat four) bytes per item; none if the item has no bits.
// One more item waits in the input register; the input stalls until the final byte
// of the draining item leaves. Reset (rst_n low, synchronous) drops all items in
// flight, clears the history and sets mode to rate half.
module conv_encoder_k7_rate_half_repeat import cer_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: mode register
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_wdata,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [11:8] bit_count, [15:12] zero
  input  logic        in_tlast,   // last_of_message
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] coded_byte, [11:8] coded_bit_count, [15:12] zero
  output logic        out_tlast   // last_of_run
);

  mode_t             mode_r;
  logic [HIST_W-1:0] hist_r;

  // Input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_data_r;
  logic [CNT_W-1:0]  s1_count_r;
  logic              s1_last_r;

  enc_res_t          enc_res;
  logic              emit_free;
  logic              load;
  logic              in_fire;
  logic [BYTE_W-1:0] out_byte;
  logic [CNT_W-1:0]  out_count;

  // Move the held item into the result register once it is free.
  assign load      = s1_valid_r && emit_free;
  assign in_tready = !s1_valid_r || emit_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      hist_r     <= '0;
      mode_r     <= MODE_RATE_HALF;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_wen) begin
        mode_r <= mode_t'(cfg_wdata);
      end
      // Advance history as the item is encoded; clear it after the last one.
      if (load) begin
        hist_r <= s1_last_r ? '0 : enc_res.hist;
      end
    end
    if (in_fire) begin
      s1_data_r  <= in_tdata[7:0];
      s1_count_r <= in_tdata[11:8];
      s1_last_r  <= in_tlast;
    end
  end

  cer_encode u_encode (
    .mode      (mode_r),
    .data_byte (s1_data_r),
    .bit_count (s1_count_r),
    .hist      (hist_r),
    .res       (enc_res)
  );

  cer_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_res   (enc_res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_byte   (out_byte),
    .out_count  (out_count),
    .out_last   (out_tlast),
    .free       (emit_free)
  );

  assign out_tdata = {4'b0, out_count, out_byte};

endmodule

[hw/rtl/cer_encode.sv]
// Combinational encoder core: turns one data item and the bit history into
// up to 64 coded bits, packed MSB first. Depends on cer_pkg.
module cer_encode import cer_pkg::*; (
  input  mode_t             mode,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [CNT_W-1:0]  bit_count,
  input  logic [HIST_W-1:0] hist,
  output enc_res_t          res
);

  always_comb begin
    logic [13:0]       seq;
    logic [CNT_W-1:0]  n;
    logic [7:0]        vmask;
    logic [7:0]        p1;
    logic [7:0]        p2;
    logic [7:0]        dmask;
    logic [BUF_W-1:0]  b_half;
    logic [BUF_W-1:0]  b_rep2;
    logic [BUF_W-1:0]  b_rep4;

    n = (bit_count > MAX_BITS) ? MAX_BITS : bit_count;

    // Oldest history bit at 0, data bits follow in arrival order.
    seq[5:0] = hist;
    for (int i = 0; i < 8; i++) begin
      seq[6+i] = data_byte[7-i];
    end

    for (int i = 0; i < 8; i++) begin
      vmask[i]    = (4'(i) < n);
      dmask[7-i]  = vmask[i];
      p1[i]       = (^(seq[i +: 7] & TAP_P1)) & vmask[i];
      p2[i]       = (^(seq[i +: 7] & TAP_P2)) & vmask[i];
    end

    b_half = '0;
    b_rep2 = '0;
    b_rep4 = '0;
    for (int i = 0; i < 8; i++) begin
      b_half[63-2*i] = p1[i];
      b_half[62-2*i] = p2[i];
      for (int r = 0; r < 2; r++) begin
        b_rep2[63-4*i-2*r] = p1[i];
        b_rep2[62-4*i-2*r] = p2[i];
      end
      for (int r = 0; r < 4; r++) begin
        b_rep4[63-8*i-2*r] = p1[i];
        b_rep4[62-8*i-2*r] = p2[i];
      end
    end

    res.hist = seq[n +: 6];
    case (mode)
      MODE_BYPASS: begin
        res.bits  = {data_byte & dmask, 56'b0};
        res.total = {3'b0, n};
        res.hist  = hist;
      end
      MODE_RATE_HALF: begin
        res.bits  = b_half;
        res.total = {2'b0, n, 1'b0};
      end
      MODE_REPEAT2: begin
        res.bits  = b_rep2;
        res.total = {1'b0, n, 2'b0};
      end
      MODE_REPEAT4: begin
        res.bits  = b_rep4;
        res.total = {n, 3'b0};
      end
      default: begin
        res.bits  = b_half;
        res.total = {2'b0, n, 1'b0};
      end
    endcase
  end

endmodule

[hw/rtl/cer_emit.sv]
// Result register: holds one item's coded bits and hands them out a byte
// per accepted result, MSB first. Depends on cer_pkg.
module cer_emit import cer_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  enc_res_t          load_res,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [BYTE_W-1:0] out_byte,
  output logic [CNT_W-1:0]  out_count,
  output logic              out_last,
  output logic              free
);

  logic [TOT_W-1:0] rem_r, rem_nxt;
  logic [BUF_W-1:0] bits_r, bits_nxt;
  logic             fire;

  assign out_tvalid = (rem_r != '0);
  assign fire       = out_tvalid && out_tready;
  assign out_last   = (rem_r <= TOT_W'(8));
  assign out_count  = out_last ? rem_r[CNT_W-1:0] : MAX_BITS;
  assign out_byte   = bits_r[BUF_W-1 -: BYTE_W];
  // Free when empty or when the final byte leaves in this cycle.
  assign free       = (rem_r == '0) || (out_tready && out_last);

  always_comb begin
    rem_nxt  = rem_r;
    bits_nxt = bits_r;
    if (load) begin
      rem_nxt  = load_res.total;
      bits_nxt = load_res.bits;
    end else if (fire) begin
      rem_nxt  = out_last ? '0 : rem_r - TOT_W'(8);
      bits_nxt = bits_r << BYTE_W;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
    bits_r <= bits_nxt;
  end

endmodule

[hw/rtl/cer_checker.sv]
// Port-level checker for conv_encoder_k7_rate_half_repeat, bound to the top.
// Depends only on the top level's ports.
module cer_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:8] != 4'd0 && out_tdata[11:8] <= 4'd8)
    else $error("coded bit count out of range");

  a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[11:8] == 4'd8)
    else $error("partial byte before the last result");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] & (8'hff >> out_tdata[11:8])) == 8'h00)
    else $error("unused coded bits not zero");

endmodule

bind conv_encoder_k7_rate_half_repeat cer_checker u_cer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[tb/conv_encoder_k7_rate_half_repeat_tb.sv]
// Self-checking testbench for the K=7 rate-1/2 convolutional encoder with repetition.
// It sends a directed table and then random messages, and checks each coded byte
// against a built-in predictor. Depends on cer_pkg and conv_encoder_k7_rate_half_repeat.
module conv_encoder_k7_rate_half_repeat_tb;
  import cer_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One coded byte as it leaves the block.
  typedef struct packed {
    logic       last;
    logic [3:0] cnt;
    logic [7:0] code;
  } coded_t;

  // One directed row: the mode it runs in, the item, and up to two coded bytes
  // typed in by hand (n_typed = 0 hands the row to the predictor).
  typedef struct packed {
    mode_t      mode;
    logic [7:0] data;
    logic [3:0] cnt;
    logic       last;
    logic [1:0] n_typed;
    coded_t     t0;
    coded_t     t1;
  } dir_row_t;

  localparam int     N_DIR       = 20;
  localparam int     SEG_ITEMS   = 15;    // random items per (idle phase, mode) segment
  localparam int     LONG_HOLD   = 150;   // receiver hold-off that backs the block up
  localparam int     CFG_SETTLE  = 8;     // cycles after the last result before a mode write
  localparam int     END_SETTLE  = 16;
  localparam int     STALL_LIMIT = 2000;  // cycles with no item moving on either side
  localparam coded_t NO_CODE     = '0;

  // Sender idle and receiver stall, percent of cycles, per random phase.
  localparam int SEND_IDLE  [4] = '{0, 63, 0, 36};
  localparam int RECV_STALL [4] = '{0, 0, 63, 36};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_wdata = 2'b00;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [7:0] data_byte, [11:8] bit_count, [15:12] zero
  logic        in_tlast = 1'b0;  // last_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [7:0] coded_byte, [11:8] coded_bit_count, [15:12] zero
  logic        out_tlast;        // last_of_run

  conv_encoder_k7_rate_half_repeat uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: our own copy of the mode register and the six-bit history.
  mode_t      coder_mode;
  logic [5:0] coder_hist;

  coded_t pending_codes[$];  // coded bytes still owed by the block, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int errors         = 0;
  int items_sent     = 0;
  int codes_checked  = 0;
  int idle_cycles    = 0;
  int mode_items [4] = '{0, 0, 0, 0};

  dir_row_t dir_rows [N_DIR];
  mode_t    mode_order [4] = '{MODE_RATE_HALF, MODE_BYPASS, MODE_REPEAT4, MODE_REPEAT2};

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Encode one item: collect the coded bytes it yields and advance the history.
  function automatic void predict_codes(input logic [7:0] d, input logic [3:0] n_in,
                                        input logic l, output coded_t outs[$]);
    logic [63:0] bits;
    logic [6:0]  win;
    logic        p1, p2;
    int          n, reps, total, nres, i, r, k;
    coded_t      c;
    bits  = '0;
    total = 0;
    outs  = {};
    n = (n_in > MAX_BITS) ? 8 : int'(n_in);
    if (coder_mode == MODE_BYPASS) begin
      // Pass the valid bits straight through; history stays put.
      for (i = 0; i < n; i++) begin
        bits[63 - total] = d[7 - i];
        total++;
      end
    end else begin
      case (coder_mode)
        MODE_RATE_HALF: reps = 1;
        MODE_REPEAT2:   reps = 2;
        default:        reps = 4;
      endcase
      for (i = 0; i < n; i++) begin
        win = {d[7 - i], coder_hist};
        p1  = ^(win & TAP_P1);
        p2  = ^(win & TAP_P2);
        for (r = 0; r < reps; r++) begin
          bits[63 - total]     = p1;
          bits[63 - total - 1] = p2;
          total += 2;
        end
        coder_hist = win[6:1];
      end
    end
    if (l) coder_hist = '0;
    nres = (total + 7) / 8;
    for (k = 0; k < nres; k++) begin
      c.code = bits[63 - 8 * k -: 8];
      c.cnt  = (total - 8 * k >= 8) ? 4'd8 : 4'(total - 8 * k);
      c.last = (k == nres - 1);
      outs.push_back(c);
    end
  endfunction

  // Hold off until every owed byte is out, then give the block some extra cycles.
  task automatic drain(input int extra);
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Offer one item, wait for the handshake, then record what it should yield.
  task automatic send_item(input logic [7:0] d, input logic [3:0] n, input logic l,
                           input int n_typed, input coded_t t0, input coded_t t1);
    coded_t outs[$];
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, n, d};
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    mode_items[coder_mode]++;
    predict_codes(d, n, l, outs);
    if (n_typed == 0) begin
      foreach (outs[i]) pending_codes.push_back(outs[i]);
    end else begin
      pending_codes.push_back(t0);
      if (n_typed > 1) pending_codes.push_back(t1);
    end
  endtask

  // Write the mode register; the task first waits until the block has gone quiet.
  task automatic set_mode(input mode_t m);
    in_tvalid <= 1'b0;
    drain(CFG_SETTLE);
    cfg_wen   <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_wen    <= 1'b0;
    coder_mode = m;
  endtask

  // Receiver: random stalls, plus one long hold-off on request so the block fills up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left   <= LONG_HOLD;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checker: compare each accepted coded byte with the oldest one owed.
  always @(posedge clk) begin
    coded_t want;
    if (rst_n && out_tvalid && out_tready) begin
      codes_checked++;
      if (pending_codes.size() == 0) begin
        flag_error($sformatf("unexpected coded byte %02h cnt %0d last %0b",
                             out_tdata[7:0], out_tdata[11:8], out_tlast));
      end else begin
        want = pending_codes.pop_front();
        if (out_tdata[7:0] != want.code || out_tdata[11:8] != want.cnt ||
            out_tlast != want.last)
          flag_error($sformatf("expected %02h cnt %0d last %0b, got %02h cnt %0d last %0b",
                               want.code, want.cnt, want.last,
                               out_tdata[7:0], out_tdata[11:8], out_tlast));
      end
    end
  end

  // Watchdog: stop a run in which no item moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles, %0d bytes owed",
               STALL_LIMIT, pending_codes.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    dir_row_t   row;
    int         ph, j, k, msg_left, roll;
    mode_t      seg_mode;
    logic [7:0] d;
    logic [3:0] n;
    logic       l;

    // Directed rows. The mode starts at its reset value (rate half) with no write.
    // Rows with typed bytes: all-zero data from a clean history, and bypass cases.
    dir_rows = '{
      '{MODE_RATE_HALF, 8'h00, 4'd8,  1'b1, 2'd2, '{1'b0, 4'd8, 8'h00}, '{1'b1, 4'd8, 8'h00}},
      '{MODE_RATE_HALF, 8'h80, 4'd1,  1'b0, 2'd0, NO_CODE, NO_CODE},  // single bit
      '{MODE_RATE_HALF, 8'hFF, 4'd8,  1'b0, 2'd0, NO_CODE, NO_CODE},
      '{MODE_RATE_HALF, 8'h5A, 4'd5,  1'b0, 2'd0, NO_CODE, NO_CODE},  // partial, no last
      '{MODE_RATE_HALF, 8'h00, 4'd0,  1'b0, 2'd0, NO_CODE, NO_CODE},  // empty item
      '{MODE_RATE_HALF, 8'hC3, 4'd15, 1'b0, 2'd0, NO_CODE, NO_CODE},  // count above eight
      '{MODE_RATE_HALF, 8'hFF, 4'd0,  1'b1, 2'd0, NO_CODE, NO_CODE},  // empty, clears history
      '{MODE_RATE_HALF, 8'h01, 4'd8,  1'b0, 2'd0, NO_CODE, NO_CODE},
      // Bypass keeps the history from the row above untouched.
      '{MODE_BYPASS,    8'hA5, 4'd8,  1'b0, 2'd1, '{1'b1, 4'd8, 8'hA5}, NO_CODE},
      '{MODE_BYPASS,    8'hFF, 4'd3,  1'b0, 2'd1, '{1'b1, 4'd3, 8'hE0}, NO_CODE},
      '{MODE_BYPASS,    8'h3C, 4'd12, 1'b0, 2'd1, '{1'b1, 4'd8, 8'h3C}, NO_CODE},
      '{MODE_BYPASS,    8'h80, 4'd1,  1'b0, 2'd1, '{1'b1, 4'd1, 8'h80}, NO_CODE},
      '{MODE_BYPASS,    8'h55, 4'd0,  1'b0, 2'd0, NO_CODE, NO_CODE},
      '{MODE_REPEAT2,   8'h96, 4'd8,  1'b0, 2'd0, NO_CODE, NO_CODE},
      '{MODE_REPEAT2,   8'h00, 4'd2,  1'b1, 2'd0, NO_CODE, NO_CODE},  // partial final item
      '{MODE_REPEAT2,   8'hFF, 4'd8,  1'b1, 2'd0, NO_CODE, NO_CODE},
      '{MODE_REPEAT4,   8'h00, 4'd8,  1'b1, 2'd0, NO_CODE, NO_CODE},
      '{MODE_REPEAT4,   8'hFF, 4'd8,  1'b0, 2'd0, NO_CODE, NO_CODE},
      '{MODE_REPEAT4,   8'h6D, 4'd3,  1'b0, 2'd0, NO_CODE, NO_CODE},
      '{MODE_REPEAT4,   8'h81, 4'd9,  1'b1, 2'd0, NO_CODE, NO_CODE}
    };

    coder_mode = MODE_RATE_HALF;
    coder_hist = '0;

    // Hold reset low at the start, then release it for good.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; switch mode only when a row asks for another one.
    for (k = 0; k < N_DIR; k++) begin
      row = dir_rows[k];
      if (row.mode != coder_mode) set_mode(row.mode);
      send_item(row.data, row.cnt, row.last, row.n_typed, row.t0, row.t1);
    end

    // Random part: four idle phases, each running every mode in turn.
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      for (j = 0; j < 4; j++) begin
        seg_mode = mode_order[(ph + j) % 4];
        set_mode(seg_mode);
        // With no idling, stall the receiver for a long stretch in the densest mode
        // while the sender keeps pushing, so the block backs up to its input.
        if (ph == 0 && seg_mode == MODE_REPEAT4) hold_asked++;
        msg_left = 0;
        for (k = 0; k < SEG_ITEMS; k++) begin
          d    = 8'($urandom_range(255));
          roll = $urandom_range(99);
          if (roll < 12) begin
            // Noise: empty items, oversized counts and partial items, each with a random last.
            case ($urandom_range(2))
              0:       n = 4'd0;
              1:       n = 4'($urandom_range(15, 9));
              default: n = 4'($urandom_range(7, 1));
            endcase
            l = 1'($urandom_range(1));
          end else begin
            // Well-formed message: full bytes, last on the final one, which may be short.
            if (msg_left == 0) msg_left = $urandom_range(6, 1);
            n = (msg_left == 1) ? 4'($urandom_range(8, 1)) : MAX_BITS;
            l = (msg_left == 1);
            msg_left--;
          end
          send_item(d, n, l, 0, NO_CODE, NO_CODE);
        end
      end
    end

    in_tvalid <= 1'b0;
    drain(END_SETTLE);
    if (pending_codes.size() != 0)
      flag_error($sformatf("%0d coded bytes never arrived", pending_codes.size()));

    $display("Covered %0d items (bypass %0d, rate half %0d, repeat two %0d, repeat four %0d),",
             items_sent, mode_items[MODE_BYPASS], mode_items[MODE_RATE_HALF],
             mode_items[MODE_REPEAT2], mode_items[MODE_REPEAT4]);
    $display("checked %0d coded bytes under sender idling, receiver stalls and one long hold.",
             codes_checked);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
